// File: hdl/gbn_pkg.sv
// Shared types, constants and datapath operation codes for the Go-Back-N sender.
package gbn_pkg;

	localparam int WINDOW_MAX   = 64;
	localparam int WIN_AW       = $clog2(WINDOW_MAX);
	localparam int PEND_DEPTH   = 256;
	localparam int PEND_AW      = $clog2(PEND_DEPTH);
	localparam int SEQ_W        = 16;
	localparam int SUM_W        = 13;
	localparam int CNT_W        = WIN_AW + 1;
	localparam int QCNT_W       = PEND_AW + 1;
	localparam int WIN_CFG_W    = 7;
	localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = 7'd8;

	localparam logic [1:0] ACT_NEW     = 2'd0;
	localparam logic [1:0] ACT_ACK     = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;

	localparam logic [1:0] TMR_NONE  = 2'd0;
	localparam logic [1:0] TMR_START = 2'd1;
	localparam logic [1:0] TMR_STOP  = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] payload_tag;
		logic [12:0] payload_sum;
		logic [15:0] ack_seq_field;
		logic [15:0] ack_num;
		logic [17:0] ack_checksum;
	} in_item_t;

	typedef struct packed {
		logic        send_valid;
		logic [15:0] seq_num;
		logic [15:0] out_tag;
		logic [16:0] out_checksum;
		logic [1:0]  timer_cmd;
		logic        dropped;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [15:0]      tag;
		logic [SUM_W-1:0] sum;
	} slot_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_SEND,
		OP_QUEUE,
		OP_DROP,
		OP_EMPTY,
		OP_SLIDE,
		OP_ACK_DONE,
		OP_DRAIN_RD,
		OP_DRAIN_SEND,
		OP_TO_EMPTY,
		OP_TO_INIT,
		OP_TO_RD,
		OP_TO_SEND
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       out_free;
		logic       win_room;
		logic       q_full;
		logic       ack_ok;
		logic       drain_ok;
		logic       drain_more;
		logic       to_empty;
		logic       to_last;
	} status_t;

endpackage

// File: hdl/gbn_ctrl.sv
// Controller state machine sequencing accept, decision, drain and resend loops.
module gbn_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  gbn_pkg::status_t sts,
	output gbn_pkg::cmd_t    cmd
);
	import gbn_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_DRAIN = 6'b000100,
		S_DRD   = 6'b001000,
		S_TO    = 6'b010000,
		S_TORD  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.op  = OP_LATCH;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.action)
					ACT_NEW: begin
						if (sts.out_free) begin
							cmd.op  = sts.win_room ? OP_SEND : (sts.q_full ? OP_DROP : OP_QUEUE);
							state_d = S_IDLE;
						end
					end
					ACT_ACK: begin
						if (sts.ack_ok) begin
							cmd.op  = OP_SLIDE;
							state_d = S_DRAIN;
						end else if (sts.out_free) begin
							cmd.op  = OP_EMPTY;
							state_d = S_IDLE;
						end
					end
					ACT_TIMEOUT: begin
						if (!sts.to_empty) begin
							cmd.op  = OP_TO_INIT;
							state_d = S_TO;
						end else if (sts.out_free) begin
							cmd.op  = OP_TO_EMPTY;
							state_d = S_IDLE;
						end
					end
					default: begin
						if (sts.out_free) begin
							cmd.op  = OP_EMPTY;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_DRAIN: begin
				if (sts.drain_ok) begin
					cmd.op  = OP_DRAIN_RD;
					state_d = S_DRD;
				end else if (sts.out_free) begin
					cmd.op  = OP_ACK_DONE;
					state_d = S_IDLE;
				end
			end
			S_DRD: begin
				if (sts.out_free) begin
					cmd.op  = OP_DRAIN_SEND;
					state_d = sts.drain_more ? S_DRAIN : S_IDLE;
				end
			end
			S_TO: begin
				cmd.op  = OP_TO_RD;
				state_d = S_TORD;
			end
			S_TORD: begin
				if (sts.out_free) begin
					cmd.op  = OP_TO_SEND;
					state_d = sts.to_last ? S_IDLE : S_TO;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/gbn_dp.sv
// Datapath: sequence state, window and pending memories, and result register.
module gbn_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gbn_pkg::in_item_t                  req,
	output gbn_pkg::out_item_t                 rsp,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	input  logic                               cfg_we,
	input  logic [gbn_pkg::WIN_CFG_W-1:0]      cfg_data,
	input  gbn_pkg::cmd_t                      cmd,
	output gbn_pkg::status_t                   sts
);
	import gbn_pkg::*;

	slot_t  win_mem [WINDOW_MAX];
	slot_t  pend_mem [PEND_DEPTH];

	in_item_t              in_q;
	out_item_t             rsp_q;
	logic                  rsp_valid_q;
	logic [WIN_CFG_W-1:0]  window_q;
	logic [SEQ_W-1:0]      base_q, next_q;
	logic [PEND_AW-1:0]    qrd_q, qwr_q;
	logic [QCNT_W-1:0]     qcnt_q;
	logic [CNT_W-1:0]      idx_q;
	slot_t                 win_rd_q, pend_rd_q;

	logic [WIN_CFG_W-1:0]  eff_win;
	logic [SEQ_W-1:0]      outst16, ack_off, to_seq;
	logic [CNT_W-1:0]      outst;
	logic [CNT_W:0]        outst_p1;
	logic [17:0]           ack_sum;
	logic                  emit;
	out_item_t             pkt_new, pkt_drain, pkt_to, empty;
	slot_t                 in_slot;

	function automatic out_item_t mk_pkt(logic [SEQ_W-1:0] seq, slot_t s, logic [1:0] tcmd,
			logic lst);
		out_item_t r;
		r.send_valid   = 1'b1;
		r.seq_num      = seq;
		r.out_tag      = s.tag;
		r.out_checksum = {1'b0, seq} + {4'd0, s.sum};
		r.timer_cmd    = tcmd;
		r.dropped      = 1'b0;
		r.last         = lst;
		return r;
	endfunction

	function automatic out_item_t mk_empty(logic [1:0] tcmd, logic drop);
		out_item_t r;
		r           = '0;
		r.timer_cmd = tcmd;
		r.dropped   = drop;
		r.last      = 1'b1;
		return r;
	endfunction

	always_comb begin
		if (window_q == '0) begin
			eff_win = WIN_CFG_W'(1);
		end else if (window_q > WIN_CFG_W'(WINDOW_MAX)) begin
			eff_win = WIN_CFG_W'(WINDOW_MAX);
		end else begin
			eff_win = window_q;
		end
	end

	assign outst16  = next_q - base_q;
	assign outst    = outst16[CNT_W-1:0];
	assign outst_p1 = {1'b0, outst} + (CNT_W+1)'(1);
	assign ack_off  = in_q.ack_num - base_q;
	assign ack_sum  = {2'd0, in_q.ack_seq_field} + {2'd0, in_q.ack_num}
		+ {5'd0, in_q.payload_sum};
	assign to_seq   = base_q + {{(SEQ_W-CNT_W){1'b0}}, idx_q};
	assign in_slot  = '{tag: in_q.payload_tag, sum: in_q.payload_sum};

	always_comb begin
		sts.action     = in_q.action;
		sts.out_free   = !rsp_valid_q || rsp_ready;
		sts.win_room   = outst16 < {{(SEQ_W-WIN_CFG_W){1'b0}}, eff_win};
		sts.q_full     = qcnt_q == QCNT_W'(PEND_DEPTH);
		sts.ack_ok     = (ack_sum == in_q.ack_checksum) && (ack_off < outst16);
		sts.drain_ok   = sts.win_room && (qcnt_q != '0);
		sts.drain_more = (outst_p1 < {1'b0, eff_win}) && (qcnt_q != '0);
		sts.to_empty   = outst16 == '0;
		sts.to_last    = ({1'b0, idx_q} + (CNT_W+1)'(1)) == {1'b0, outst};
	end

	always_comb begin
		empty     = '0;
		empty.last = 1'b1;
		pkt_new   = mk_pkt(next_q, in_slot, (base_q == next_q) ? TMR_START : TMR_NONE, 1'b1);
		pkt_drain = mk_pkt(next_q, pend_rd_q, sts.drain_more ? TMR_NONE : TMR_START,
			!sts.drain_more);
		pkt_to    = mk_pkt(to_seq, win_rd_q, (idx_q == '0) ? TMR_START : TMR_NONE,
			sts.to_last);
		emit = 1'b1;
		case (cmd.op)
			OP_SEND, OP_QUEUE, OP_DROP, OP_EMPTY, OP_ACK_DONE, OP_DRAIN_SEND, OP_TO_EMPTY,
			OP_TO_SEND: emit = 1'b1;
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_SEND) begin
			win_mem[next_q[WIN_AW-1:0]] <= in_slot;
		end else if (cmd.op == OP_DRAIN_SEND) begin
			win_mem[next_q[WIN_AW-1:0]] <= pend_rd_q;
		end
		if (cmd.op == OP_TO_RD) begin
			win_rd_q <= win_mem[to_seq[WIN_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_QUEUE) begin
			pend_mem[qwr_q] <= in_slot;
		end
		if (cmd.op == OP_DRAIN_RD) begin
			pend_rd_q <= pend_mem[qrd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			in_q <= req;
		end
		case (cmd.op)
			OP_SEND:       rsp_q <= pkt_new;
			OP_DRAIN_SEND: rsp_q <= pkt_drain;
			OP_TO_SEND:    rsp_q <= pkt_to;
			OP_DROP:       rsp_q <= mk_empty(TMR_NONE, 1'b1);
			OP_ACK_DONE:   rsp_q <= mk_empty((base_q == next_q) ? TMR_STOP : TMR_START, 1'b0);
			OP_TO_EMPTY:   rsp_q <= mk_empty(TMR_START, 1'b0);
			OP_QUEUE, OP_EMPTY: rsp_q <= empty;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			base_q      <= '0;
			next_q      <= '0;
			qrd_q       <= '0;
			qwr_q       <= '0;
			qcnt_q      <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_data;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_SEND, OP_DRAIN_SEND: next_q <= next_q + SEQ_W'(1);
				OP_QUEUE: begin
					qwr_q  <= qwr_q + PEND_AW'(1);
					qcnt_q <= qcnt_q + QCNT_W'(1);
				end
				OP_SLIDE: base_q <= in_q.ack_num + SEQ_W'(1);
				OP_DRAIN_RD: begin
					qrd_q  <= qrd_q + PEND_AW'(1);
					qcnt_q <= qcnt_q - QCNT_W'(1);
				end
				OP_TO_INIT: idx_q <= '0;
				OP_TO_SEND: idx_q <= idx_q + CNT_W'(1);
				default: ;
			endcase
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// File: hdl/go_back_n_sender_top.sv
// Top level of the Go-Back-N sender: controller plus datapath.
// Sequencing: an accepted request is latched in IDLE and decided in EXEC; a message or ignored
// event then registers its result; a valid ack slides the window in EXEC, then passes DRAIN and
// DRD once per drained packet before its result; a timeout with packets outstanding loops TO and
// TORD once per resent packet. A new request is taken only back in IDLE; a waiting result stalls.
// Reset (arst_n low): window 8, sequence numbers, queue pointers and count cleared.
module go_back_n_sender_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  gbn_pkg::in_item_t             req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output gbn_pkg::out_item_t            rsp,
	input  logic                          cfg_we,
	input  logic [gbn_pkg::WIN_CFG_W-1:0] cfg_data
);
	import gbn_pkg::*;

	cmd_t    cmd;
	status_t sts;

	gbn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gbn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: test/tb_go_back_n_sender_top.sv
// Self-checking testbench for go_back_n_sender_top: directed table, then random phases.
module tb_go_back_n_sender_top;
	import gbn_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_BAD = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	in_item_t    req;
	logic        rsp_valid;
	logic        rsp_ready;
	out_item_t   rsp;
	logic        cfg_we;
	logic [WIN_CFG_W-1:0] cfg_data;

	// sender model state
	logic [WIN_CFG_W-1:0] win_reg;
	logic [15:0] base_seq_m;
	logic [15:0] next_seq_m;
	slot_t       win_mem [WINDOW_MAX];
	slot_t       pend_mem [PEND_DEPTH];
	int          q_rd;
	int          q_wr;
	int          q_cnt;

	out_item_t   pkt_q[$];
	stim_row_t   dir_rows[$];
	int          errors;
	int          snd_idle_pct;
	int          rcv_stall_pct;
	bit          hold_req;
	int          quiet_cycles;

	go_back_n_sender_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report(string fld, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h", fld, got, want);
		errors++;
	endtask

	function automatic int eff_window();
		if (win_reg == 0)
			return 1;
		if (win_reg > WINDOW_MAX)
			return WINDOW_MAX;
		return int'(win_reg);
	endfunction

	function automatic void push_result(bit sv, logic [15:0] s, slot_t sl, logic [1:0] t,
			bit drop);
		out_item_t r;
		r = '0;
		r.send_valid = sv;
		if (sv) begin
			r.seq_num      = s;
			r.out_tag      = sl.tag;
			r.out_checksum = {1'b0, s} + {4'b0, sl.sum};
		end
		r.timer_cmd = t;
		r.dropped   = drop;
		pkt_q.push_back(r);
	endfunction

	function automatic void send_slot(slot_t sl, logic [1:0] t);
		win_mem[next_seq_m % WINDOW_MAX] = sl;
		push_result(1'b1, next_seq_m, sl, t, 1'b0);
		next_seq_m = next_seq_m + 16'd1;
	endfunction

	function automatic void predict_packets(in_item_t it);
		slot_t       sl;
		logic [15:0] outs;
		logic [15:0] s;
		int          n;
		bit          ok;
		sl.tag = it.payload_tag;
		sl.sum = it.payload_sum;
		outs = next_seq_m - base_seq_m;
		n = 0;
		case (it.action)
			ACT_NEW: begin
				if (outs < eff_window())
					send_slot(sl, (base_seq_m == next_seq_m) ? TMR_START : TMR_NONE);
				else if (q_cnt < PEND_DEPTH) begin
					pend_mem[q_wr] = sl;
					q_wr = (q_wr + 1) % PEND_DEPTH;
					q_cnt++;
					push_result(1'b0, '0, sl, TMR_NONE, 1'b0);
				end else
					push_result(1'b0, '0, sl, TMR_NONE, 1'b1);
			end
			ACT_ACK: begin
				ok = (int'(it.ack_seq_field) + int'(it.ack_num) + int'(it.payload_sum))
					== int'(it.ack_checksum);
				if (ok && (it.ack_num - base_seq_m) < outs) begin
					base_seq_m = it.ack_num + 16'd1;
					while (16'(next_seq_m - base_seq_m) < eff_window() && q_cnt > 0) begin
						sl = pend_mem[q_rd];
						q_rd = (q_rd + 1) % PEND_DEPTH;
						q_cnt--;
						send_slot(sl, TMR_NONE);
						n++;
					end
					if (n == 0)
						push_result(1'b0, '0, sl,
							(base_seq_m == next_seq_m) ? TMR_STOP : TMR_START, 1'b0);
					else
						pkt_q[$].timer_cmd = TMR_START;
				end else
					push_result(1'b0, '0, sl, TMR_NONE, 1'b0);
			end
			ACT_TIMEOUT: begin
				for (int i = 0; i < outs && i < WINDOW_MAX; i++) begin
					s = base_seq_m + 16'(i);
					push_result(1'b1, s, win_mem[s % WINDOW_MAX],
						(i == 0) ? TMR_START : TMR_NONE, 1'b0);
					n++;
				end
				if (n == 0)
					push_result(1'b0, '0, sl, TMR_START, 1'b0);
			end
			default: push_result(1'b0, '0, sl, TMR_NONE, 1'b0);
		endcase
		pkt_q[$].last = 1'b1;
	endfunction

	task automatic offer(in_item_t it, bit typed, out_item_t want);
		if (snd_idle_pct > 0 && $urandom_range(0, 99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(0, 99) < snd_idle_pct);
		end
		req_valid <= 1'b1;
		req       <= it;
		do
			@(posedge clk);
		while (!req_ready);
		predict_packets(it);
		if (typed) begin
			void'(pkt_q.pop_back());
			pkt_q.push_back(want);
		end
		@(negedge clk);
	endtask

	task automatic set_window(logic [WIN_CFG_W-1:0] v);
		req_valid <= 1'b0;
		while (pkt_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we  <= 1'b0;
		win_reg = v;
	endtask

	function automatic in_item_t rand_item(int new_pct);
		in_item_t    it;
		logic [15:0] outs;
		int          pick;
		it.action        = ACT_NEW;
		it.payload_tag   = 16'($urandom);
		it.payload_sum   = ($urandom_range(0, 3) == 0) ? 13'($urandom) :
			13'($urandom_range(0, 5100));
		it.ack_seq_field = 16'($urandom);
		it.ack_num       = 16'($urandom);
		it.ack_checksum  = 18'($urandom);
		outs = next_seq_m - base_seq_m;
		pick = $urandom_range(0, 99);
		if (pick < new_pct)
			return it;
		pick = $urandom_range(0, 99);
		if (pick < 65 && outs != 0) begin
			it.action  = ACT_ACK;
			it.ack_num = base_seq_m + 16'($urandom_range(0, outs - 1));
			it.ack_checksum = 18'(int'(it.ack_seq_field) + int'(it.ack_num)
				+ int'(it.payload_sum));
		end else if (pick < 80)
			it.action = ACT_TIMEOUT;
		else if (pick < 88) begin
			it.action = ACT_ACK;
			it.ack_checksum = 18'(int'(it.ack_seq_field) + int'(it.ack_num)
				+ int'(it.payload_sum) + $urandom_range(1, 1000));
		end else if (pick < 95) begin
			it.action  = ACT_ACK;
			it.ack_num = base_seq_m + outs + 16'($urandom_range(0, 60000));
			it.ack_checksum = 18'(int'(it.ack_seq_field) + int'(it.ack_num)
				+ int'(it.payload_sum));
		end else
			it.action = ($urandom_range(0, 1) == 0) ? ACT_BAD : ACT_ACK;
		return it;
	endfunction

	task automatic add_row(logic [1:0] a, logic [15:0] tag, logic [12:0] sum,
			logic [15:0] aseq, logic [15:0] anum, logic [17:0] achk, bit typed,
			logic sv, logic [15:0] s, logic [15:0] otag, logic [16:0] ochk,
			logic [1:0] t);
		stim_row_t r;
		r.item  = '{a, tag, sum, aseq, anum, achk};
		r.typed = typed;
		r.want  = '{sv, s, otag, ochk, t, 1'b0, 1'b1};
		dir_rows.push_back(r);
	endtask

	// receiver
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	// checker and watchdog
	always @(posedge clk) begin
		out_item_t e;
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("go_back_n_sender_top verification failed");
			$finish;
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pkt_q.size() == 0) begin
				report("unexpected transaction on rsp", 32'd1, 32'd0);
			end else begin
				e = pkt_q.pop_front();
				if (rsp.send_valid !== e.send_valid)
					report("send_valid", rsp.send_valid, e.send_valid);
				if (rsp.seq_num !== e.seq_num)
					report("seq_num", rsp.seq_num, e.seq_num);
				if (rsp.out_tag !== e.out_tag)
					report("out_tag", rsp.out_tag, e.out_tag);
				if (rsp.out_checksum !== e.out_checksum)
					report("out_checksum", rsp.out_checksum, e.out_checksum);
				if (rsp.timer_cmd !== e.timer_cmd)
					report("timer_cmd", rsp.timer_cmd, e.timer_cmd);
				if (rsp.dropped !== e.dropped)
					report("dropped", rsp.dropped, e.dropped);
				if (rsp.last !== e.last)
					report("last", rsp.last, e.last);
			end
		end
	end

	initial begin
		int          wins[6];
		int          idles[6];
		int          stalls[6];
		int          counts[6];
		int          bias[6];
		out_item_t   none_item;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		cfg_we       = 1'b0;
		cfg_data     = '0;
		errors       = 0;
		quiet_cycles = 0;
		hold_req     = 1'b0;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		none_item    = '0;
		win_reg      = WINDOW_RESET;
		base_seq_m   = '0;
		next_seq_m   = '0;
		q_rd = 0;
		q_wr = 0;
		q_cnt = 0;

		add_row(ACT_TIMEOUT, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, TMR_START);
		add_row(ACT_ACK, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, TMR_NONE);
		add_row(ACT_BAD, 16'hFFFF, 13'h1FFF, 16'hFFFF, 16'hFFFF, 18'h3FFFF, 1,
			0, 0, 0, 0, TMR_NONE);
		add_row(ACT_NEW, 16'hFFFF, 13'h1FFF, 0, 0, 0, 1, 1, 0, 16'hFFFF, 17'h1FFF,
			TMR_START);
		add_row(ACT_NEW, 0, 0, 0, 0, 0, 1, 1, 1, 0, 1, TMR_NONE);
		for (int i = 0; i < 6; i++)
			add_row(ACT_NEW, 16'h1234 + i, 13'd100 * i, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(ACT_NEW, 16'hAAAA, 13'd5100, 0, 0, 0, 1, 0, 0, 0, 0, TMR_NONE);
		add_row(ACT_NEW, 16'h5555, 13'h0AAA, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(ACT_ACK, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, TMR_NONE);
		add_row(ACT_ACK, 0, 0, 0, 100, 100, 1, 0, 0, 0, 0, TMR_NONE);
		add_row(ACT_TIMEOUT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(ACT_ACK, 0, 3, 5, 0, 8, 0, 0, 0, 0, 0, 0);
		add_row(ACT_ACK, 0, 0, 0, 8, 8, 0, 0, 0, 0, 0, 0);
		add_row(ACT_ACK, 0, 0, 16'hFFFF, 9, 18'h10008, 1, 0, 0, 0, 0, TMR_STOP);
		add_row(ACT_TIMEOUT, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, TMR_START);

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

		wins   = '{1, 64, 0, 127, 3, 100};
		idles  = '{0, 67, 0, 15, 0, 67};
		stalls = '{0, 0, 67, 15, 0, 67};
		counts = '{262, 60, 40, 50, 30, 20};
		bias   = '{100, 30, 45, 40, 45, 40};
		for (int p = 0; p < 6; p++) begin
			set_window(wins[p]);
			snd_idle_pct  = idles[p];
			rcv_stall_pct = stalls[p];
			for (int k = 0; k < counts[p]; k++) begin
				if (p == 0 && k == 20)
					hold_req = 1'b1;
				offer(rand_item(bias[p]), 1'b0, none_item);
			end
		end
		req_valid <= 1'b0;
		while (pkt_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0 && pkt_q.size() == 0)
			$display("go_back_n_sender_top verification clean");
		else
			$display("go_back_n_sender_top verification failed");
		$finish;
	end
endmodule
